// File: rtl/cste_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the cubic spline table evaluator
// no dependencies
package cste_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int DATA_W         = 32;
    localparam int IDX_W          = 6;
    localparam int CFG_W          = 7;
    localparam int STATUS_W       = 2;
    localparam int QUEUE_DEPTH    = 2;
    localparam int ENTRY_W        = 3 * DATA_W;

    localparam logic [CFG_W-1:0]    ACTIVE_POINTS_RST = CFG_W'(2);
    localparam logic [STATUS_W-1:0] ST_INSIDE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BELOW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABOVE  = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_QUERY,
        OP_DROP
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic [IDX_W-1:0]         knot_index;
        logic signed [DATA_W-1:0] coordinate;
        logic signed [DATA_W-1:0] value;
        logic signed [DATA_W-1:0] curvature;
        logic signed [DATA_W:0]   point_abs;
    } item_t;

endpackage

// File: rtl/cste_if.sv
`timescale 1ns / 1ps
// input and result channel interfaces
// depends on cste_pkg
interface cste_in_if;
    import cste_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      action;
    logic [IDX_W-1:0]          knot_index;
    logic signed [DATA_W-1:0]  knot_coordinate;
    logic signed [DATA_W-1:0]  knot_value;
    logic signed [DATA_W-1:0]  knot_curvature;
    logic signed [DATA_W-1:0]  query_point;
    modport source (output valid, action, knot_index, knot_coordinate, knot_value,
                    knot_curvature, query_point, input ready);
    modport sink (input valid, action, knot_index, knot_coordinate, knot_value,
                  knot_curvature, query_point, output ready);
endinterface

interface cste_out_if;
    import cste_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [DATA_W-1:0]  result_value;
    logic [STATUS_W-1:0]       range_status;
    modport source (output valid, result_value, range_status, input ready);
    modport sink (input valid, result_value, range_status, output ready);
endinterface

// File: rtl/cste_ram.sv
`timescale 1ns / 1ps
// generic single write, single read ram with registered read data
// no dependencies
module cste_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

// File: rtl/cste_front.sv
`timescale 1ns / 1ps
// front end: accepts items, classifies them and queues them for the back end
// depends on cste_pkg and cste_if
module cste_front #(
    parameter int MAX_POINTS = cste_pkg::MAX_POINTS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    cste_in_if.sink         in_ch,
    output logic            q_valid,
    output cste_pkg::item_t q_item,
    input  logic            q_pop
);
    import cste_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    item_t              slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W:0]     count_reg;
    item_t              cls;
    logic               push;
    logic               pop;

    always_comb
    begin
        cls.knot_index = in_ch.knot_index;
        cls.coordinate = in_ch.knot_coordinate;
        cls.value      = in_ch.knot_value;
        cls.curvature  = in_ch.knot_curvature;
        if (in_ch.query_point < 0)
        begin
            cls.point_abs = -{in_ch.query_point[DATA_W-1], in_ch.query_point};
        end
        else
        begin
            cls.point_abs = {in_ch.query_point[DATA_W-1], in_ch.query_point};
        end
        if (in_ch.action)
        begin
            cls.op = OP_QUERY;
        end
        else if (32'(in_ch.knot_index) < MAX_POINTS)
        begin
            cls.op = OP_LOAD;
        end
        else
        begin
            cls.op = OP_DROP;
        end
    end

    assign in_ch.ready = (count_reg < (PTR_W+1)'(QUEUE_DEPTH));
    assign push    = in_ch.valid && in_ch.ready && (cls.op != OP_DROP);
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign pop     = q_pop && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                slot_reg[wr_ptr_reg] <= cls;
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: rtl/cste_back.sv
`timescale 1ns / 1ps
// back end: table writes, interval search, weight division and spline sum
// depends on cste_pkg, cste_if and cste_ram
module cste_back #(
    parameter int MAX_POINTS = cste_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = cste_pkg::FRAC_BITS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [cste_pkg::CFG_W-1:0] active_points,
    input  logic                      q_valid,
    input  cste_pkg::item_t           q_item,
    output logic                      q_pop,
    cste_out_if.source                out_ch
);
    import cste_pkg::*;

    localparam int AW       = $clog2(MAX_POINTS);
    localparam int H2_STEPS = 16;
    localparam int CNT_W    = 5;
    localparam logic [63:0] MAG_LIMIT = 64'd1 << 40;
    localparam logic signed [63:0] SUM_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SUM_MIN = -64'sd2147483648;

    typedef enum logic [3:0] {
        S_IDLE, S_CHK_LAST, S_CHK_FIRST, S_SRCH, S_SRCH_W, S_RD_LO, S_RD_HI,
        S_SETUP, S_DIV, S_H2, S_MUL, S_MWB, S_DONE
    } state_t;

    typedef enum logic [3:0] {
        M_AA, M_AAA, M_BB, M_BBB, M_AY, M_BY, M_AC, M_BC, M_CH
    } step_t;

    state_t                    state_reg;
    step_t                     step_reg;
    logic [CNT_W-1:0]          cnt_reg;
    logic [AW-1:0]             klo_reg;
    logic [AW-1:0]             khi_reg;
    logic [AW-1:0]             mid_reg;
    logic signed [DATA_W:0]    p_reg;
    logic signed [DATA_W-1:0]  xlo_reg;
    logic signed [DATA_W-1:0]  xhi_reg;
    logic signed [DATA_W-1:0]  y0_reg;
    logic signed [DATA_W-1:0]  y1_reg;
    logic signed [DATA_W-1:0]  c0_reg;
    logic signed [DATA_W-1:0]  c1_reg;
    logic signed [DATA_W:0]    h_reg;
    logic [63:0]               hh_reg;
    logic [DATA_W:0]           rem_reg;
    logic [FRAC_BITS:0]        q_reg;
    logic [63:0]               m_reg;
    logic [1:0]                r3_reg;
    logic [63:0]               h2_reg;
    logic signed [63:0]        t_reg;
    logic signed [63:0]        ca_reg;
    logic signed [63:0]        cb_reg;
    logic signed [63:0]        lin_reg;
    logic signed [63:0]        curv_reg;
    logic [63:0]               prod_reg;
    logic [1:0]                pidx_reg;
    logic [127:0]              acc_reg;
    logic signed [DATA_W-1:0]  pend_val_reg;
    logic [STATUS_W-1:0]       pend_st_reg;
    logic                      out_valid_reg;
    logic signed [DATA_W-1:0]  out_val_reg;
    logic [STATUS_W-1:0]       out_st_reg;

    logic [AW-1:0]             last_idx;
    logic [AW-1:0]             raddr;
    logic [ENTRY_W-1:0]        rdata;
    logic signed [DATA_W-1:0]  rd_x;
    logic signed [DATA_W-1:0]  rd_y;
    logic signed [DATA_W-1:0]  rd_c;
    logic                      ram_we;
    logic [AW-1:0]             k_mid;
    logic                      more_search;
    logic signed [63:0]        a_val;
    logic signed [63:0]        b_val;
    logic signed [63:0]        opx;
    logic signed [63:0]        opy;
    logic [63:0]               ux;
    logic [63:0]               uy;
    logic                      neg;
    logic [127:0]              shifted;
    logic [63:0]               mag;
    logic signed [63:0]        mres;
    logic signed [63:0]        sum;
    logic signed [DATA_W+1:0]  dd;
    logic [DATA_W:0]           d_clamp;
    logic                      ge;
    logic [DATA_W:0]           rem_after;
    logic [5:0]                cur3;
    logic [13:0]               cur_mul;
    logic [3:0]                qd3;
    logic [5:0]                r3_next;
    logic [DATA_W-1:0]         h_u;

    always_comb
    begin
        int n;
        n = int'(active_points);
        if (n < 2)
        begin
            n = 2;
        end
        if (n > MAX_POINTS)
        begin
            n = MAX_POINTS;
        end
        last_idx = AW'(n - 1);
    end

    assign rd_x = rdata[DATA_W-1:0];
    assign rd_y = rdata[2*DATA_W-1:DATA_W];
    assign rd_c = rdata[3*DATA_W-1:2*DATA_W];

    assign k_mid       = AW'(({1'b0, khi_reg} + {1'b0, klo_reg}) >> 1);
    assign more_search = (AW'(khi_reg - klo_reg) > AW'(1)) && (AW > 1);

    assign q_pop  = (state_reg == S_IDLE) && q_valid;
    assign ram_we = q_pop && (q_item.op == OP_LOAD);

    always_comb
    begin
        case (state_reg)
            S_IDLE:      raddr = last_idx;
            S_SRCH:      raddr = more_search ? k_mid : klo_reg;
            S_RD_LO:     raddr = khi_reg;
            default:     raddr = '0;
        endcase
    end

    cste_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_tables (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(q_item.knot_index)),
        .wdata ({q_item.curvature, q_item.value, q_item.coordinate}),
        .raddr (raddr),
        .rdata (rdata)
    );

    // division step for the interval weight
    assign h_u       = h_reg[DATA_W-1:0];
    assign ge        = (rem_reg >= {1'b0, h_u});
    assign rem_after = ge ? (rem_reg - {1'b0, h_u}) : rem_reg;
    assign dd        = {xhi_reg[DATA_W-1], xhi_reg[DATA_W-1], xhi_reg}
                       - {p_reg[DATA_W], p_reg};
    always_comb
    begin
        if (dd < 0)
        begin
            d_clamp = '0;
        end
        else if (dd > {h_reg[DATA_W], h_reg})
        begin
            d_clamp = h_reg;
        end
        else
        begin
            d_clamp = dd[DATA_W:0];
        end
    end

    // radix-16 digit of the divide by three
    assign cur3    = {r3_reg, m_reg[63:60]};
    assign cur_mul = 14'(cur3) * 14'd171;
    assign qd3     = cur_mul[12:9];
    assign r3_next = cur3 - 6'(qd3) * 6'd3;

    // fixed-point multiply operands
    assign a_val = 64'(q_reg);
    assign b_val = (64'sd1 <<< FRAC_BITS) - a_val;

    always_comb
    begin
        case (step_reg)
            M_AA:    begin opx = a_val;    opy = a_val;             end
            M_AAA:   begin opx = t_reg;    opy = a_val;             end
            M_BB:    begin opx = b_val;    opy = b_val;             end
            M_BBB:   begin opx = t_reg;    opy = b_val;             end
            M_AY:    begin opx = a_val;    opy = 64'(y0_reg);       end
            M_BY:    begin opx = b_val;    opy = 64'(y1_reg);       end
            M_AC:    begin opx = ca_reg;   opy = 64'(c0_reg);       end
            M_BC:    begin opx = cb_reg;   opy = 64'(c1_reg);       end
            M_CH:    begin opx = curv_reg; opy = h2_reg;            end
            default: begin opx = '0;       opy = '0;                end
        endcase
    end

    assign ux      = (opx < 0) ? (64'd0 - 64'(opx)) : 64'(opx);
    assign uy      = (opy < 0) ? (64'd0 - 64'(opy)) : 64'(opy);
    assign neg     = (opx < 0) != (opy < 0);
    assign shifted = acc_reg >> FRAC_BITS;
    assign mag     = (shifted > 128'(MAG_LIMIT)) ? MAG_LIMIT : shifted[63:0];
    assign mres    = neg ? -$signed(mag) : $signed(mag);
    assign sum     = lin_reg + mres;

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result_value = out_val_reg;
    assign out_ch.range_status = out_st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= M_AA;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ch.ready && (state_reg != S_DONE))
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid && (q_item.op == OP_QUERY))
                    begin
                        p_reg     <= q_item.point_abs;
                        state_reg <= S_CHK_LAST;
                    end
                end
                S_CHK_LAST:
                begin
                    if (p_reg > $signed({rd_x[DATA_W-1], rd_x}))
                    begin
                        pend_val_reg <= rd_y;
                        pend_st_reg  <= ST_ABOVE;
                        state_reg    <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_CHK_FIRST;
                    end
                end
                S_CHK_FIRST:
                begin
                    if (p_reg < $signed({rd_x[DATA_W-1], rd_x}))
                    begin
                        pend_val_reg <= rd_y;
                        pend_st_reg  <= ST_BELOW;
                        state_reg    <= S_DONE;
                    end
                    else
                    begin
                        klo_reg   <= '0;
                        khi_reg   <= last_idx;
                        state_reg <= S_SRCH;
                    end
                end
                S_SRCH:
                begin
                    if (more_search)
                    begin
                        mid_reg   <= k_mid;
                        state_reg <= S_SRCH_W;
                    end
                    else
                    begin
                        state_reg <= S_RD_LO;
                    end
                end
                S_SRCH_W:
                begin
                    if ($signed({rd_x[DATA_W-1], rd_x}) > p_reg)
                    begin
                        khi_reg <= mid_reg;
                    end
                    else
                    begin
                        klo_reg <= mid_reg;
                    end
                    state_reg <= S_SRCH;
                end
                S_RD_LO:
                begin
                    xlo_reg   <= rd_x;
                    y0_reg    <= rd_y;
                    c0_reg    <= rd_c;
                    state_reg <= S_RD_HI;
                end
                S_RD_HI:
                begin
                    xhi_reg   <= rd_x;
                    y1_reg    <= rd_y;
                    c1_reg    <= rd_c;
                    h_reg     <= {rd_x[DATA_W-1], rd_x} - {xlo_reg[DATA_W-1], xlo_reg};
                    state_reg <= S_SETUP;
                end
                S_SETUP:
                begin
                    if (h_reg <= 0)
                    begin
                        pend_val_reg <= y0_reg;
                        pend_st_reg  <= ST_INSIDE;
                        state_reg    <= S_DONE;
                    end
                    else
                    begin
                        hh_reg    <= 64'(h_u) * 64'(h_u);
                        rem_reg   <= d_clamp;
                        cnt_reg   <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    q_reg   <= {q_reg[FRAC_BITS-1:0], ge};
                    rem_reg <= {rem_after[DATA_W-1:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(FRAC_BITS))
                    begin
                        m_reg     <= hh_reg >> (FRAC_BITS + 1);
                        r3_reg    <= '0;
                        cnt_reg   <= '0;
                        state_reg <= S_H2;
                    end
                end
                S_H2:
                begin
                    h2_reg  <= {h2_reg[59:0], qd3};
                    r3_reg  <= r3_next[1:0];
                    m_reg   <= {m_reg[59:0], 4'd0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(H2_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        acc_reg   <= '0;
                        step_reg  <= M_AA;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    if (cnt_reg < CNT_W'(4))
                    begin
                        prod_reg <= (cnt_reg[1] ? ux[63:32] : ux[31:0])
                                    * (cnt_reg[0] ? uy[63:32] : uy[31:0]);
                        pidx_reg <= cnt_reg[1:0];
                    end
                    if (cnt_reg != '0)
                    begin
                        acc_reg <= acc_reg + ((128'(prod_reg))
                                   << (32 * (int'(pidx_reg[1]) + int'(pidx_reg[0]))));
                    end
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(4))
                    begin
                        state_reg <= S_MWB;
                    end
                end
                S_MWB:
                begin
                    cnt_reg   <= '0;
                    acc_reg   <= '0;
                    state_reg <= S_MUL;
                    case (step_reg)
                        M_AA:  begin t_reg <= mres;               step_reg <= M_AAA; end
                        M_AAA: begin ca_reg <= mres - a_val;      step_reg <= M_BB;  end
                        M_BB:  begin t_reg <= mres;               step_reg <= M_BBB; end
                        M_BBB: begin cb_reg <= mres - b_val;      step_reg <= M_AY;  end
                        M_AY:  begin lin_reg <= mres;             step_reg <= M_BY;  end
                        M_BY:  begin lin_reg <= lin_reg + mres;   step_reg <= M_AC;  end
                        M_AC:  begin curv_reg <= mres;            step_reg <= M_BC;  end
                        M_BC:  begin curv_reg <= curv_reg + mres; step_reg <= M_CH;  end
                        default:
                        begin
                            if (sum > SUM_MAX)
                            begin
                                pend_val_reg <= SUM_MAX[DATA_W-1:0];
                            end
                            else if (sum < SUM_MIN)
                            begin
                                pend_val_reg <= SUM_MIN[DATA_W-1:0];
                            end
                            else
                            begin
                                pend_val_reg <= sum[DATA_W-1:0];
                            end
                            pend_st_reg <= ST_INSIDE;
                            state_reg   <= S_DONE;
                        end
                    endcase
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_val_reg   <= pend_val_reg;
                        out_st_reg    <= pend_st_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/cubic_spline_table_eval.sv
`timescale 1ns / 1ps
// top level of the cubic spline table evaluator
// depends on cste_pkg, cste_if, cste_front and cste_back
//
//  channel   dir   handshake            payload
//  in_ch     in    valid / ready        action, knot_index, knot_*, query_point
//  out_ch    out   valid / ready        result_value, range_status
//  cfg       in    cfg_wr_en            cfg_wr_data -> active_points
//
// a load is written to the table as the back end pops it; a query outside the
// knots ends after the checks of the last and first knot; one inside goes
// through those checks, the interval search and reads, a divider giving
// FRAC_BITS+1 weight bits, the h*h/6 term and 9 shared multiplies
// the two-entry queue keeps taking transfers while the back end works or a
// result waits, until it is full; async active-low reset sets active_points
// to 2, tables hold garbage until loaded
module cubic_spline_table_eval #(
    parameter int MAX_POINTS = cste_pkg::MAX_POINTS_DEF,
    parameter int FRAC_BITS  = cste_pkg::FRAC_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    cste_in_if.sink                    in_ch,
    cste_out_if.source                 out_ch,
    input  logic                       cfg_wr_en,
    input  logic [cste_pkg::CFG_W-1:0] cfg_wr_data
);
    import cste_pkg::*;

    logic [CFG_W-1:0] active_points_reg;
    logic             q_valid;
    item_t            q_item;
    logic             q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_points_reg <= ACTIVE_POINTS_RST;
        end
        else if (cfg_wr_en)
        begin
            active_points_reg <= cfg_wr_data;
        end
    end

    cste_front #(
        .MAX_POINTS (MAX_POINTS)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    cste_back #(
        .MAX_POINTS (MAX_POINTS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .active_points (active_points_reg),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .q_pop         (q_pop),
        .out_ch        (out_ch)
    );

endmodule
